>>> rtl/core/cbaa_pkg.sv
// shared types and constants of the processor-bandwidth admission block
package cbaa_pkg;

  localparam int CAP_W     = 27;
  localparam int DATA_W    = 32;
  localparam int LOAD_W    = 20;
  localparam int REQ_W     = 2;
  localparam int RATE_W    = 5;
  localparam int SCALE_W   = 20;
  localparam int GRANT_W   = 52;
  localparam int TAX_W     = 8;
  localparam int USER_W    = 10;
  localparam int DRAW_W    = 17;
  localparam int LEFT_W    = 10;
  localparam int S_TDATA_W = 152;
  localparam int M_TDATA_W = 224;
  localparam int APB_AW    = 3;

  localparam logic [REQ_W-1:0] REQ_ADMIT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_BURN  = 2'd2;

  localparam logic [CAP_W-1:0]   CAP_RESET = 27'd1000000;
  localparam logic [SCALE_W-1:0] BW_SCALE  = 20'd1000000;

  localparam int LOAD_UNIT  = 1000;
  localparam int PERCENT    = 100;
  localparam int RATE_FLOOR = 1;
  localparam int RATE_CEIL  = 20;

  // decoded request as it sits in the queue
  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [DATA_W-1:0] cost;
    logic [DATA_W-1:0] period;
    logic [RATE_W-1:0] rate;
    logic              intr;
    logic              adm;
    logic [DATA_W-1:0] budget;
    logic [DATA_W-1:0] burn;
  } cmd_t;

  // result item, last member in the lowest bits
  typedef struct packed {
    logic [DATA_W-1:0]  kernel_pool;
    logic [CAP_W-1:0]   free_total;
    logic [CAP_W-1:0]   reserved_total;
    logic               kernel_deficit;
    logic               budget_exhausted;
    logic [DATA_W-1:0]  budget_after;
    logic [LEFT_W-1:0]  left_tokens;
    logic [DRAW_W-1:0]  reserved_draw;
    logic [USER_W-1:0]  net_supply;
    logic [TAX_W-1:0]   tax_tokens;
    logic [GRANT_W-1:0] granted_bandwidth;
    logic               status;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [CAP_W-1:0] data;
  } cfg_wr_t;

endpackage

>>> rtl/core/cbaa_front.sv
// front end: takes request transfers, decodes fields and the tax rate
module cbaa_front (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [cbaa_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [cbaa_pkg::REQ_W-1:0]     s_tuser,
  input  logic                           q_full,
  output logic                           q_push,
  output cbaa_pkg::cmd_t                 q_data
);
  import cbaa_pkg::*;

  logic [LOAD_W-1:0] load;
  logic [RATE_W-1:0] rate;

  assign load = s_tdata[83:64];

  // tax rate 1 + load/1000, clamped to 20
  always_comb begin
    rate = RATE_W'(RATE_FLOOR);
    for (int k = 1; k < RATE_CEIL; k++) begin
      if (load >= LOAD_W'(k * LOAD_UNIT)) begin
        rate = RATE_W'(RATE_FLOOR + k);
      end
    end
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_data        = '0;
    q_data.req    = s_tuser;
    q_data.cost   = s_tdata[31:0];
    q_data.period = s_tdata[63:32];
    q_data.rate   = rate;
    q_data.intr   = s_tdata[84];
    q_data.adm    = s_tdata[85];
    q_data.budget = s_tdata[117:86];
    q_data.burn   = s_tdata[149:118];
  end

endmodule

>>> rtl/core/cbaa_queue.sv
// two-entry queue of decoded requests between front and back end
module cbaa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cbaa_pkg::cmd_t wdata,
  input  logic           pop,
  output cbaa_pkg::cmd_t rdata,
  output logic           full,
  output logic           empty
);
  import cbaa_pkg::*;

  cmd_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("pop from empty queue");

endmodule

>>> rtl/core/cbaa_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module cbaa_div #(
  parameter int N = 52,
  parameter int D = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);
  localparam int CW = $clog2(N + 1);

  logic [D:0]    rem;
  logic [N-1:0]  quo;
  logic [D-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic          run;
  logic [D:0]    shifted;
  logic [D:0]    trial;

  assign shifted  = {rem[D-1:0], quo[N-1]};
  assign trial    = shifted - {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (run) begin
      rem <= trial[D] ? shifted : trial;
      quo <= {quo[N-2:0], !trial[D]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(N);
      end else if (run) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/cbaa_back.sv
// back end: bandwidth bank state, multiply/divide sequencer, result register
module cbaa_back #(
  parameter int TICK_SUPPLY = 1000
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cbaa_pkg::cfg_wr_t          cfg,
  output logic [cbaa_pkg::CAP_W-1:0] capacity,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  cbaa_pkg::cmd_t             q_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output cbaa_pkg::res_t             out_res
);
  import cbaa_pkg::*;

  localparam int TAX_MAXV = TICK_SUPPLY * RATE_CEIL / PERCENT;
  localparam int TXW      = $clog2(TAX_MAXV + 1);
  localparam int USW      = $clog2(TICK_SUPPLY + 1);
  localparam int MBW      = (USW > SCALE_W) ? USW : SCALE_W;
  localparam int PW       = DATA_W + MBW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]        state;
  cmd_t              cmd;
  logic [PW-1:0]     prod;
  logic [TXW-1:0]    tax_r;
  logic [USW-1:0]    user_r;
  logic [CAP_W-1:0]  reserved;
  logic [CAP_W-1:0]  free_bw;
  logic [DATA_W-1:0] pool;

  logic [CAP_W-1:0]  reserved_next;
  logic [CAP_W-1:0]  free_next;
  logic [DATA_W-1:0] pool_next;
  res_t              res_c;

  logic [TXW-1:0]    tax_tab [2**RATE_W];
  logic [TXW-1:0]    tax_c;
  logic [USW-1:0]    user_c;
  logic              is_tick;
  logic              need_div;
  logic [DATA_W-1:0] mul_a;
  logic [MBW-1:0]    mul_b;
  logic              div_start;
  logic              div_done;
  logic [PW-1:0]     q;
  logic [DATA_W-1:0] div_dsr;
  logic [PW:0]       admit_sum;
  logic [DATA_W:0]   pool_sum;
  logic [USW-1:0]    left_full;
  logic              res_load;

  // tax tokens per rate, rates above the cap read as the cap
  for (genvar r = 0; r < 2**RATE_W; r++) begin : g_tax
    assign tax_tab[r] = TXW'(TICK_SUPPLY * ((r > RATE_CEIL) ? RATE_CEIL : r) / PERCENT);
  end

  assign tax_c    = tax_tab[cmd.rate];
  assign user_c   = USW'(TICK_SUPPLY) - USW'(tax_c);
  assign is_tick  = (cmd.req == REQ_TICK);
  assign need_div = is_tick || ((cmd.req == REQ_ADMIT) && (cmd.period != '0));

  // one shared multiplier: cost*1e6 for admit, reserved*user for tick
  assign mul_a   = is_tick ? DATA_W'(reserved) : cmd.cost;
  assign mul_b   = is_tick ? MBW'(user_r) : MBW'(BW_SCALE);
  assign div_dsr = is_tick ? DATA_W'(BW_SCALE) : cmd.period;
  assign prod    = mul_a * mul_b;

  assign div_start = (state == ST_START);
  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign res_load  = (state == ST_DONE) && (!out_valid || out_ready);

  cbaa_div #(
    .N (PW),
    .D (DATA_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (q)
  );

  assign admit_sum = {1'b0, q} + (PW+1)'(reserved);
  assign pool_sum  = {1'b0, pool} + (DATA_W+1)'(tax_r);
  assign left_full = (PW'(user_r) > q) ? (user_r - USW'(q)) : '0;

  always_comb begin
    res_c              = '0;
    res_c.budget_after = cmd.budget;
    reserved_next      = reserved;
    free_next          = free_bw;
    pool_next          = pool;
    case (cmd.req)
      REQ_ADMIT: begin
        if (cmd.period == '0) begin
          res_c.status = 1'b1;
        end else begin
          res_c.granted_bandwidth = GRANT_W'(q);
          if (admit_sum > (PW+1)'(capacity)) begin
            res_c.status = 1'b1;
          end else begin
            reserved_next = reserved + q[CAP_W-1:0];
            free_next     = (PW'(free_bw) >= q) ? (free_bw - q[CAP_W-1:0]) : '0;
          end
        end
      end
      REQ_TICK: begin
        pool_next           = pool_sum[DATA_W] ? '1 : pool_sum[DATA_W-1:0];
        res_c.tax_tokens    = TAX_W'(tax_r);
        res_c.net_supply    = USER_W'(user_r);
        res_c.reserved_draw = DRAW_W'(q);
        res_c.left_tokens   = LEFT_W'(left_full);
      end
      REQ_BURN: begin
        if (cmd.intr) begin
          if (pool >= cmd.burn) begin
            pool_next = pool - cmd.burn;
          end else begin
            pool_next            = '0;
            res_c.kernel_deficit = 1'b1;
          end
        end else if (cmd.adm) begin
          if (cmd.budget >= cmd.burn) begin
            res_c.budget_after = cmd.budget - cmd.burn;
          end else begin
            res_c.budget_after     = '0;
            res_c.budget_exhausted = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res_c.reserved_total = reserved_next;
    res_c.free_total     = free_next;
    res_c.kernel_pool    = pool_next;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_data;
    end
    if (state == ST_MUL) begin
      tax_r  <= tax_c;
      user_r <= user_c;
    end
    if (res_load) begin
      out_res <= res_c;
    end
  end

  // sequencer, bank state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      capacity  <= CAP_RESET;
      reserved  <= '0;
      free_bw   <= CAP_RESET;
      pool      <= '0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= need_div ? ST_START : ST_DONE;
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (res_load) begin
        reserved <= reserved_next;
      end
      if (cfg.we) begin
        capacity <= cfg.data;
        free_bw  <= cfg.data;
        pool     <= '0;
      end else if (res_load) begin
        free_bw <= free_next;
        pool    <= pool_next;
      end
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
      div_done |-> state == ST_DIV)
    else $error("divider finished outside of divide wait");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
      (out_valid && !out_ready) |-> !res_load)
    else $error("result register overwritten while stalled");
  a_reserved_hold: assert property (@(posedge clk) disable iff (rst)
      (!res_load && !rst) |=> $stable(reserved))
    else $error("reserved bandwidth changed without a result");

endmodule

>>> rtl/core/cpu_bandwidth_admission_accounting.sv
// top level of the processor-bandwidth admission and accounting block
//
//  channel  | dir | handshake              | content
//  ---------+-----+------------------------+--------------------------------------
//  s_*      | in  | s_tvalid / s_tready    | request: kind in tuser, operands tdata
//  m_*      | out | m_tvalid / m_tready    | one result transfer per request
//  apb      | in  | psel & penable, pready | capacity register at byte address 0
//
//  admit with nonzero period and tick: through the radix-2 divider, one bit a cycle
//  burn, zero-period admit and unknown kinds: no divide
//  a two-entry queue lets the front take two more requests while the back works
//  reset is synchronous: capacity and free bandwidth 1000000, reserved and pool 0
//  a stalled result holds in the output register; the back end waits behind it
module cpu_bandwidth_admission_accounting #(
  parameter int TICK_SUPPLY = 1000
) (
  input  logic                           clk,
  input  logic                           rst,
  // slave side
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // tdata: cost_us[31:0], period[63:32], system_load[83:64], in_interrupt[84],
  //        task_admitted[85], task_budget[117:86], burn_time_us[149:118], zero fill
  input  logic [cbaa_pkg::S_TDATA_W-1:0] s_tdata,
  // tuser: req_type[1:0]
  input  logic [cbaa_pkg::REQ_W-1:0]     s_tuser,
  // master side
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // tdata: status[0], granted_bandwidth[52:1], tax_tokens[60:53],
  //        net_supply[70:61], reserved_draw[87:71], left_tokens[97:88],
  //        budget_after[129:98], budget_exhausted[130], kernel_deficit[131],
  //        reserved_total[158:132], free_total[185:159], kernel_pool[217:186],
  //        zero fill
  output logic [cbaa_pkg::M_TDATA_W-1:0] m_tdata,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cbaa_pkg::APB_AW-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import cbaa_pkg::*;

  cmd_t             push_data;
  cmd_t             head;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  cfg_wr_t          cfg;
  logic [CAP_W-1:0] capacity;
  res_t             res;
  logic             cap_sel;

  // single register, selected by the word address bit
  assign cap_sel  = !paddr[2];
  assign pready   = 1'b1;
  assign cfg.we   = psel && penable && pwrite && cap_sel;
  assign cfg.data = pwdata[CAP_W-1:0];
  assign prdata   = cap_sel ? 32'(capacity) : '0;

  cbaa_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  // decoupling queue between classification and execution
  cbaa_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (push_data),
    .pop   (q_pop),
    .rdata (head),
    .full  (q_full),
    .empty (q_empty)
  );

  cbaa_back #(
    .TICK_SUPPLY (TICK_SUPPLY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .capacity  (capacity),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (head),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // result struct already lies last field lowest
  assign m_tdata = {(M_TDATA_W - $bits(res_t))'(0), res};

endmodule

>>> tb/testbench.sv
// self-checking testbench for the processor-bandwidth admission and accounting block
module testbench;
  import cbaa_pkg::*;

  // request kind that the block ignores
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  // byte address of the capacity register
  localparam logic [APB_AW-1:0] REG_CAPACITY = '0;
  localparam longint unsigned TICK_SUPPLY = 1000;
  localparam longint unsigned POOL_MAX = 64'hFFFF_FFFF;
  localparam logic [CAP_W-1:0] CAP_MAX = 27'd67108864;
  // limit leaves room for the slowest items, stalls, the long hold-off and drains
  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD = 300;
  localparam int TAIL_CYCLES = 60;

  // one request as the sender sees it
  typedef struct {
    logic [REQ_W-1:0]  kind;
    logic [DATA_W-1:0] cost;
    logic [DATA_W-1:0] period;
    logic [LOAD_W-1:0] load;
    logic              intr;
    logic              adm;
    logic [DATA_W-1:0] budget;
    logic [DATA_W-1:0] burn;
  } bw_req_t;

  // bandwidth bookkeeping mirror: predicts each report and checks it on arrival
  class bandwidth_ledger;
    longint unsigned capacity, reserved, free_bw, pool;
    res_t due[$];
    int mismatches, n_checked;
    int n_grant, n_refuse, n_tick, n_burn, n_unknown, n_deficit, n_exhausted;

    function new();
      capacity = CAP_RESET;
      reserved = 0;
      free_bw  = CAP_RESET;
      pool     = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = value;
      free_bw  = value;
      pool     = 0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void note_request(bw_req_t r);
      res_t e;
      longint unsigned cost64, load64, granted, rate, tax, user, draw;
      e = '0;
      e.budget_after = r.budget;
      case (r.kind)
        REQ_ADMIT: begin
          if (r.period == 0) begin
            e.status = 1'b1;
            n_refuse++;
          end else begin
            cost64 = r.cost;
            granted = cost64 * BW_SCALE / r.period;
            e.granted_bandwidth = GRANT_W'(granted);
            if (reserved + granted > capacity) begin
              e.status = 1'b1;
              n_refuse++;
            end else begin
              reserved += granted;
              free_bw = (free_bw >= granted) ? free_bw - granted : 0;
              n_grant++;
            end
          end
        end
        REQ_TICK: begin
          // tax rate in percent grows with load, clamped
          load64 = r.load;
          rate = RATE_FLOOR + load64 / LOAD_UNIT;
          if (rate > RATE_CEIL) rate = RATE_CEIL;
          tax = TICK_SUPPLY * rate / PERCENT;
          pool += tax;
          if (pool > POOL_MAX) pool = POOL_MAX;
          user = TICK_SUPPLY - tax;
          draw = reserved * user / BW_SCALE;
          e.tax_tokens    = TAX_W'(tax);
          e.net_supply    = USER_W'(user);
          e.reserved_draw = DRAW_W'(draw);
          e.left_tokens   = LEFT_W'((user > draw) ? user - draw : 0);
          n_tick++;
        end
        REQ_BURN: begin
          if (r.intr) begin
            if (pool >= r.burn) begin
              pool -= r.burn;
            end else begin
              pool = 0;
              e.kernel_deficit = 1'b1;
              n_deficit++;
            end
          end else if (r.adm) begin
            if (r.budget >= r.burn) begin
              e.budget_after = r.budget - r.burn;
            end else begin
              e.budget_after = '0;
              e.budget_exhausted = 1'b1;
              n_exhausted++;
            end
          end
          n_burn++;
        end
        default: begin
          n_unknown++;
        end
      endcase
      e.reserved_total = CAP_W'(reserved);
      e.free_total     = CAP_W'(free_bw);
      e.kernel_pool    = DATA_W'(pool);
      due.push_back(e);
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch in report %0d, %s: expected %0h, got %0h",
                   n_checked, name, want, got);
      end
    endfunction

    function void check_report(res_t got);
      res_t e;
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("report transfer with no request outstanding");
        return;
      end
      e = due.pop_front();
      compare("status", e.status, got.status);
      compare("granted_bandwidth", e.granted_bandwidth, got.granted_bandwidth);
      compare("tax_tokens", e.tax_tokens, got.tax_tokens);
      compare("net_supply", e.net_supply, got.net_supply);
      compare("reserved_draw", e.reserved_draw, got.reserved_draw);
      compare("left_tokens", e.left_tokens, got.left_tokens);
      compare("budget_after", e.budget_after, got.budget_after);
      compare("budget_exhausted", e.budget_exhausted, got.budget_exhausted);
      compare("kernel_deficit", e.kernel_deficit, got.kernel_deficit);
      compare("reserved_total", e.reserved_total, got.reserved_total);
      compare("free_total", e.free_total, got.free_total);
      compare("kernel_pool", e.kernel_pool, got.kernel_pool);
      n_checked++;
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [REQ_W-1:0]     s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [APB_AW-1:0]    paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  bandwidth_ledger ledger = new();

  // receiver controls: random stall rate, one long hold-off, and a calm tail
  int rx_idle_pct = 0;
  bit rx_hold_req = 1'b0;
  bit calm = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  int cycles = 0;

  cpu_bandwidth_admission_accounting #(
    .TICK_SUPPLY(int'(TICK_SUPPLY))
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycles, ledger.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  // report side: check each transfer, then pick next cycle's tready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      ledger.check_report(res_t'(m_tdata[$bits(res_t)-1:0]));
    if (rx_hold_req) begin
      hold_left = LONG_HOLD;
      rx_hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      // long hold-off: lets the queue fill so the request side backs up
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < rx_idle_pct) begin
      stall_left = $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // every field random, so fields a kind ignores still toggle
  function automatic bw_req_t random_fields(logic [REQ_W-1:0] kind);
    bw_req_t r;
    r.kind   = kind;
    r.cost   = $urandom;
    r.period = $urandom;
    r.load   = LOAD_W'($urandom);
    r.intr   = 1'($urandom_range(0, 1));
    r.adm    = 1'($urandom_range(0, 1));
    r.budget = $urandom;
    r.burn   = $urandom;
    return r;
  endfunction

  // one request transfer; tvalid stays high for the caller to keep or drop
  task automatic push_req(input bw_req_t r);
    s_tvalid <= 1'b1;
    s_tuser  <= r.kind;
    s_tdata  <= {2'b00, r.burn, r.budget, r.adm, r.intr, r.load, r.period, r.cost};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ledger.note_request(r);
  endtask

  // sender pause until every outstanding report has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_CAPACITY;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ledger.set_capacity(value);
  endtask

  // random phase: a mix of admits, ticks, burns and junk kinds
  task automatic run_random(input int count, input int tx_idle_pct);
    bw_req_t r;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        r = random_fields(REQ_ADMIT);
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          // well-formed reservation of roughly 10 to 10000 tokens
          r.period = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 100000) : ($urandom | 1);
          r.cost = r.period / $urandom_range(100, 100000);
        end else if (pick < 75) begin
          r.period = '0;
        end
      end else if (pick < 60) begin
        r = random_fields(REQ_TICK);
        if ($urandom_range(0, 1) != 0) r.load = LOAD_W'($urandom_range(0, 21000));
      end else if (pick < 90) begin
        r = random_fields(REQ_BURN);
        if ($urandom_range(0, 1) != 0) r.burn = $urandom_range(0, 300);
        if ($urandom_range(0, 1) != 0) r.budget = $urandom_range(0, 400);
      end else begin
        r = random_fields(REQ_UNKNOWN);
      end
      push_req(r);
      if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  endtask

  initial begin
    bw_req_t r;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at the reset capacity of 1000000
    r = random_fields(REQ_ADMIT); r.period = '0; push_req(r);             // zero period refused
    r = random_fields(REQ_ADMIT); r.cost = '0; r.period = 32'd1; push_req(r);
    r = random_fields(REQ_ADMIT); r.cost = 32'd100; r.period = 32'd1000; push_req(r);
    r = random_fields(REQ_ADMIT); r.cost = '1; r.period = '1; push_req(r);  // over capacity
    r = random_fields(REQ_ADMIT); r.cost = '1; r.period = 32'd1; push_req(r); // widest grant
    r = random_fields(REQ_ADMIT); r.cost = 32'd1; r.period = '1; push_req(r); // rounds to zero
    r = random_fields(REQ_ADMIT); r.cost = 32'd900; r.period = 32'd1000; push_req(r); // exact fit
    // tax rate steps and clamp
    r = random_fields(REQ_TICK); r.load = 20'd0; push_req(r);
    r = random_fields(REQ_TICK); r.load = 20'd999; push_req(r);
    r = random_fields(REQ_TICK); r.load = 20'd1000; push_req(r);
    r = random_fields(REQ_TICK); r.load = 20'd18999; push_req(r);
    r = random_fields(REQ_TICK); r.load = 20'd19000; push_req(r);
    r = random_fields(REQ_TICK); r.load = 20'd20000; push_req(r);
    r = random_fields(REQ_TICK); r.load = '1; push_req(r);
    // kernel pool burns: none, covered, deficit
    r = random_fields(REQ_BURN); r.intr = 1'b1; r.burn = '0; push_req(r);
    r = random_fields(REQ_BURN); r.intr = 1'b1; r.burn = 32'd50; push_req(r);
    r = random_fields(REQ_BURN); r.intr = 1'b1; r.burn = '1; push_req(r);
    // task budget burns
    r = random_fields(REQ_BURN); r.intr = 1'b0; r.adm = 1'b1;
    r.budget = 32'd500; r.burn = 32'd200; push_req(r);
    r = random_fields(REQ_BURN); r.intr = 1'b0; r.adm = 1'b1;
    r.budget = 32'd100; r.burn = 32'd101; push_req(r);
    r = random_fields(REQ_BURN); r.intr = 1'b0; r.adm = 1'b1;
    r.budget = '1; r.burn = '1; push_req(r);
    // interrupt context wins over an admitted task
    r = random_fields(REQ_BURN); r.intr = 1'b1; r.adm = 1'b1; r.burn = 32'd5; push_req(r);
    // neither context: nothing changes
    r = random_fields(REQ_BURN); r.intr = 1'b0; r.adm = 1'b0; push_req(r);
    r = random_fields(REQ_UNKNOWN); push_req(r);
    drain();

    // capacity 67108864; report side holds off at first so the request side stalls
    write_capacity(CAP_MAX);
    rx_idle_pct = 25;
    rx_hold_req = 1'b1;
    run_random(150, 25);
    drain();

    // capacity of 1: every admit with a nonzero grant is refused
    write_capacity(27'd1);
    rx_idle_pct = 10;
    run_random(60, 40);
    drain();

    write_capacity(CAP_W'($urandom_range(1, CAP_MAX)));
    rx_idle_pct = 40;
    run_random(90, 10);
    drain();

    // back to the reset capacity, full rate on both sides
    write_capacity(CAP_RESET);
    calm = 1'b1;
    run_random(80, 0);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d grants, %0d refusals, %0d ticks, %0d burns, %0d unknown kinds",
             ledger.n_grant, ledger.n_refuse, ledger.n_tick, ledger.n_burn, ledger.n_unknown);
    $display("%0d kernel deficits, %0d exhausted budgets, %0d reports checked, %0d mismatches",
             ledger.n_deficit, ledger.n_exhausted, ledger.n_checked, ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/cbaa_pkg.sv
rtl/core/cbaa_front.sv
rtl/core/cbaa_queue.sv
rtl/core/cbaa_div.sv
rtl/core/cbaa_back.sv
rtl/core/cpu_bandwidth_admission_accounting.sv
tb/testbench.sv
